// ===== src/eased_rect_glide_top_assert.svh =====
// Assertion macros for the eased rectangle glide block.
// Used by the port checker; no other dependencies.
`ifndef EASED_RECT_GLIDE_TOP_ASSERT_SVH
`define EASED_RECT_GLIDE_TOP_ASSERT_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ERG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/erg_pkg.sv =====
// Shared types and constants for the eased rectangle glide block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package erg_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DIFF_BITS  = POS_BITS + 1;
    localparam int CFG_BITS   = 20;
    localparam int E_BITS     = 17;
    localparam int Q_BITS     = 16;
    localparam int TIME_BITS  = 32;
    localparam int CTX_BITS   = 8;
    localparam int NUM_COORDS = 4;
    localparam int IDX_BITS   = 2;
    localparam int CNT_BITS   = 4;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [E_BITS-1:0]   E_ONE                = 17'h10000;
    localparam logic [CFG_BITS-1:0] GLIDE_DURATION_RESET = 20'd170000;
    localparam logic [CFG_BITS-1:0] SNAP_GAP_RESET       = 20'd120000;

    typedef enum logic {
        REG_GLIDE_DURATION = 1'b0,
        REG_SNAP_GAP       = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CTX_BITS-1:0]          context_id;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic signed [COORD_BITS-1:0] target_w;
        logic signed [COORD_BITS-1:0] target_h;
        logic [TIME_BITS-1:0]         time_us;
        logic                         tab_sliding;
    } frame_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] draw_x;
        logic signed [COORD_BITS-1:0] draw_y;
        logic signed [COORD_BITS-1:0] draw_w;
        logic signed [COORD_BITS-1:0] draw_h;
    } draw_t;

    typedef struct packed {
        logic                capture;
        logic                eval;
        logic                check;
        logic                div_step;
        logic                mul_t2;
        logic                mul_t3;
        logic                pos_step;
        logic                load_out;
        logic [IDX_BITS-1:0] pos_idx;
    } cmd_t;

    typedef struct packed {
        logic snap;
        logic ease_one;
    } sts_t;

endpackage

// ===== src/erg_ctrl.sv =====
// Sequencer for the eased rectangle glide block: steps one request through
// evaluate, divide, ease and position phases. Depends on erg_pkg.
`timescale 1ns / 1ps

module erg_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            frame_valid,
    output logic            frame_ready,
    output logic            draw_valid,
    input  logic            draw_ready,
    input  erg_pkg::sts_t   sts,
    output erg_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_T2,
        S_T3,
        S_POS,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [erg_pkg::CNT_BITS-1:0]    cnt_reg;
    logic                            out_valid_reg;
    logic                            load_w;

    assign frame_ready = (state_reg == S_IDLE);
    assign draw_valid  = out_valid_reg;
    assign load_w      = (state_reg == S_OUT) && (!out_valid_reg || draw_ready);

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && frame_valid;
        cmd.eval     = (state_reg == S_EVAL);
        cmd.check    = (state_reg == S_CHECK);
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_t2   = (state_reg == S_T2);
        cmd.mul_t3   = (state_reg == S_T3);
        cmd.pos_step = (state_reg == S_POS);
        cmd.load_out = load_w;
        cmd.pos_idx  = cnt_reg[erg_pkg::IDX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_w)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (draw_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (frame_valid)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= sts.snap ? S_OUT : S_CHECK;
                end
                S_CHECK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= sts.ease_one ? S_POS : S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg)
                    begin
                        state_reg <= S_T2;
                    end
                end
                S_T2:
                begin
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg[erg_pkg::IDX_BITS-1:0])
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (load_w)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/erg_dp.sv =====
// Datapath for the eased rectangle glide block: glide state, restoring
// divider, shared multiplier and output register. Depends on erg_pkg.
`timescale 1ns / 1ps

module erg_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  erg_pkg::frame_t                frame,
    input  erg_pkg::cmd_t                  cmd,
    input  logic [erg_pkg::CFG_BITS-1:0]   glide_duration,
    input  logic [erg_pkg::CFG_BITS-1:0]   snap_gap,
    output erg_pkg::sts_t                  sts,
    output erg_pkg::draw_t                 draw
);

    localparam int PROD_BITS = erg_pkg::DIFF_BITS + erg_pkg::E_BITS + 1;
    localparam int SQ_BITS   = 2 * erg_pkg::E_BITS;
    localparam logic signed [erg_pkg::DIFF_BITS-1:0] ROUND_HALF =
        erg_pkg::DIFF_BITS'(1) << (erg_pkg::FRAC_BITS - 1);

    // Captured request
    logic [erg_pkg::CTX_BITS-1:0]          ctx_reg;
    logic signed [erg_pkg::COORD_BITS-1:0] tgt_reg [erg_pkg::NUM_COORDS];
    logic [erg_pkg::TIME_BITS-1:0]         now_reg;
    logic                                  sliding_reg;

    // Glide state
    logic [erg_pkg::CTX_BITS-1:0]          last_ctx_reg;
    logic                                  drawn_reg;
    logic [erg_pkg::TIME_BITS-1:0]         last_time_reg;
    logic                                  active_reg;
    logic [erg_pkg::TIME_BITS-1:0]         gst_reg;
    logic signed [erg_pkg::POS_BITS-1:0]   start_reg [erg_pkg::NUM_COORDS];
    logic signed [erg_pkg::COORD_BITS-1:0] goal_reg  [erg_pkg::NUM_COORDS];
    logic signed [erg_pkg::POS_BITS-1:0]   cur_reg   [erg_pkg::NUM_COORDS];

    // Ease arithmetic
    logic [erg_pkg::CFG_BITS-1:0]          rem_reg;
    logic [erg_pkg::Q_BITS-1:0]            q_reg;
    logic [erg_pkg::E_BITS-1:0]            t_reg;
    logic [erg_pkg::E_BITS-1:0]            t2_reg;
    logic [erg_pkg::E_BITS-1:0]            e_reg;
    erg_pkg::draw_t                        draw_reg;

    logic [erg_pkg::TIME_BITS-1:0]         gap_w;
    logic [erg_pkg::TIME_BITS-1:0]         el_w;
    logic                                  changed_w;
    logic [erg_pkg::CFG_BITS:0]            rem_sh_w;
    logic                                  div_ge_w;
    logic [erg_pkg::CFG_BITS:0]            rem_sub_w;
    logic [erg_pkg::E_BITS-1:0]            t_w;
    logic [SQ_BITS-1:0]                    sq_w;
    logic [SQ_BITS-1:0]                    cube_w;
    logic signed [erg_pkg::DIFF_BITS-1:0]  goal_fix_w;
    logic signed [erg_pkg::DIFF_BITS-1:0]  start_ext_w;
    logic signed [erg_pkg::DIFF_BITS-1:0]  diff_w;
    logic signed [PROD_BITS-1:0]           prod_w;
    logic signed [PROD_BITS-1:0]           step_w;
    logic [erg_pkg::POS_BITS-1:0]          pos_new_w;

    function automatic logic signed [erg_pkg::COORD_BITS-1:0] round_pos
    (
        input logic signed [erg_pkg::POS_BITS-1:0] pos
    );
        logic signed [erg_pkg::DIFF_BITS-1:0] sum;
        sum = erg_pkg::DIFF_BITS'(pos) + ROUND_HALF;
        return sum[erg_pkg::POS_BITS-1:erg_pkg::FRAC_BITS];
    endfunction

    always_comb
    begin
        gap_w     = now_reg - last_time_reg;
        el_w      = now_reg - gst_reg;
        changed_w = 1'b0;
        for (int i = 0; i < erg_pkg::NUM_COORDS; i++)
        begin
            if (tgt_reg[i] != goal_reg[i])
            begin
                changed_w = 1'b1;
            end
        end
        sts.snap = (ctx_reg != last_ctx_reg) || !drawn_reg ||
                   (gap_w > erg_pkg::TIME_BITS'(snap_gap)) || sliding_reg;
        sts.ease_one = !active_reg || (el_w >= erg_pkg::TIME_BITS'(glide_duration));

        rem_sh_w  = {rem_reg, 1'b0};
        div_ge_w  = rem_sh_w >= {1'b0, glide_duration};
        rem_sub_w = rem_sh_w - {1'b0, glide_duration};

        t_w    = erg_pkg::E_ONE - {1'b0, q_reg};
        sq_w   = t_w * t_w;
        cube_w = t2_reg * t_reg;

        goal_fix_w  = erg_pkg::DIFF_BITS'(goal_reg[cmd.pos_idx]) <<< erg_pkg::FRAC_BITS;
        start_ext_w = erg_pkg::DIFF_BITS'(start_reg[cmd.pos_idx]);
        diff_w      = goal_fix_w - start_ext_w;
        prod_w      = diff_w * $signed({1'b0, e_reg});
        step_w      = prod_w >>> erg_pkg::Q_BITS;
        pos_new_w   = start_reg[cmd.pos_idx] + step_w[erg_pkg::POS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawn_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            drawn_reg <= 1'b1;
            if (sts.snap)
            begin
                active_reg <= 1'b0;
            end
            else if (changed_w)
            begin
                active_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ctx_reg     <= frame.context_id;
            tgt_reg[0]  <= frame.target_x;
            tgt_reg[1]  <= frame.target_y;
            tgt_reg[2]  <= frame.target_w;
            tgt_reg[3]  <= frame.target_h;
            now_reg     <= frame.time_us;
            sliding_reg <= frame.tab_sliding;
        end

        if (cmd.eval)
        begin
            last_ctx_reg  <= ctx_reg;
            last_time_reg <= now_reg;
            if (sts.snap)
            begin
                for (int i = 0; i < erg_pkg::NUM_COORDS; i++)
                begin
                    goal_reg[i]  <= tgt_reg[i];
                    start_reg[i] <= {tgt_reg[i], {erg_pkg::FRAC_BITS{1'b0}}};
                    cur_reg[i]   <= {tgt_reg[i], {erg_pkg::FRAC_BITS{1'b0}}};
                end
            end
            else if (changed_w)
            begin
                gst_reg <= now_reg;
                for (int i = 0; i < erg_pkg::NUM_COORDS; i++)
                begin
                    goal_reg[i]  <= tgt_reg[i];
                    start_reg[i] <= cur_reg[i];
                end
            end
        end

        if (cmd.check)
        begin
            e_reg   <= erg_pkg::E_ONE;
            rem_reg <= el_w[erg_pkg::CFG_BITS-1:0];
            q_reg   <= '0;
        end

        if (cmd.div_step)
        begin
            rem_reg <= div_ge_w ? rem_sub_w[erg_pkg::CFG_BITS-1:0]
                                : rem_sh_w[erg_pkg::CFG_BITS-1:0];
            q_reg   <= {q_reg[erg_pkg::Q_BITS-2:0], div_ge_w};
        end

        if (cmd.mul_t2)
        begin
            t_reg  <= t_w;
            t2_reg <= sq_w[erg_pkg::Q_BITS +: erg_pkg::E_BITS];
        end

        if (cmd.mul_t3)
        begin
            e_reg <= erg_pkg::E_ONE - cube_w[erg_pkg::Q_BITS +: erg_pkg::E_BITS];
        end

        if (cmd.pos_step)
        begin
            cur_reg[cmd.pos_idx] <= pos_new_w;
        end

        if (cmd.load_out)
        begin
            draw_reg.draw_x <= round_pos(cur_reg[0]);
            draw_reg.draw_y <= round_pos(cur_reg[1]);
            draw_reg.draw_w <= round_pos(cur_reg[2]);
            draw_reg.draw_h <= round_pos(cur_reg[3]);
        end
    end

    assign draw = draw_reg;

endmodule

// ===== src/eased_rect_glide_top.sv =====
// Eased rectangle glide: each frame request returns the rectangle to draw,
// easing out along 1-(1-t)^3 toward a changed target over the configured
// duration and snapping on a new context, the first frame, a long frame gap
// or a tab slide. One request is worked at a time. A snapping request goes
// straight from evaluation to the output; a request with no glide in progress
// runs only the four coordinate updates; a request inside a glide first runs
// the 16-step restoring divider for the elapsed fraction and two cube
// multiplies, then four coordinate updates through one shared multiplier. The
// next request is taken in the cycle after the result is loaded.
// Built from erg_pkg, erg_ctrl and erg_dp; configuration through APB.
`timescale 1ns / 1ps

module eased_rect_glide_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [erg_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [erg_pkg::DATA_BITS-1:0]  pwdata,
    output logic [erg_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           frame_valid,
    output logic                           frame_ready,
    input  erg_pkg::frame_t                frame,
    output logic                           draw_valid,
    input  logic                           draw_ready,
    output erg_pkg::draw_t                 draw
);

    logic [erg_pkg::CFG_BITS-1:0] glide_duration_reg;
    logic [erg_pkg::CFG_BITS-1:0] snap_gap_reg;
    erg_pkg::reg_index_t          reg_sel;
    logic                         wr_en;
    erg_pkg::cmd_t                cmd;
    erg_pkg::sts_t                sts;

    assign pready  = 1'b1;
    assign reg_sel = erg_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            erg_pkg::REG_GLIDE_DURATION:
                prdata = erg_pkg::DATA_BITS'(glide_duration_reg);
            erg_pkg::REG_SNAP_GAP:
                prdata = erg_pkg::DATA_BITS'(snap_gap_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_duration_reg <= erg_pkg::GLIDE_DURATION_RESET;
            snap_gap_reg       <= erg_pkg::SNAP_GAP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                erg_pkg::REG_GLIDE_DURATION:
                    glide_duration_reg <= pwdata[erg_pkg::CFG_BITS-1:0];
                erg_pkg::REG_SNAP_GAP:
                    snap_gap_reg <= pwdata[erg_pkg::CFG_BITS-1:0];
                default:
                    snap_gap_reg <= snap_gap_reg;
            endcase
        end
    end

    erg_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .draw_valid  (draw_valid),
        .draw_ready  (draw_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    erg_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame          (frame),
        .cmd            (cmd),
        .glide_duration (glide_duration_reg),
        .snap_gap       (snap_gap_reg),
        .sts            (sts),
        .draw           (draw)
    );

endmodule

// ===== src/erg_checker.sv =====
// Port-level checks for the eased rectangle glide block, bound to the top.
// Depends on erg_pkg and eased_rect_glide_top_assert.svh.
`timescale 1ns / 1ps
`include "eased_rect_glide_top_assert.svh"

module erg_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pready,
    input logic                           frame_valid,
    input logic                           frame_ready,
    input logic                           draw_valid,
    input logic                           draw_ready,
    input erg_pkg::draw_t                 draw
);

    `ERG_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
    `ERG_ASSERT_NEXT(a_busy_after_accept, frame_valid && frame_ready, !frame_ready, "request taken while busy")
    `ERG_ASSERT_NOW(a_result_after_work, $rose(draw_valid), $past(!frame_ready), "result without request")
    `ERG_ASSERT_NEXT(a_draw_hold, draw_valid && !draw_ready, draw_valid && $stable(draw), "stalled result changed")

endmodule

bind eased_rect_glide_top erg_checker u_erg_checker (.*);

// ===== bench/erg_glide_checker.sv =====
// Checker for the eased rectangle glide block: follows APB writes and frame requests,
// predicts each draw rectangle and compares it with what the block returns.
// Depends on erg_pkg for the request and result types.
`timescale 1ns / 1ps

module erg_glide_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [erg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [erg_pkg::DATA_BITS-1:0] pwdata,
    input  logic                          frame_valid,
    input  logic                          frame_ready,
    input  erg_pkg::frame_t               frame,
    input  logic                          draw_valid,
    input  logic                          draw_ready,
    input  erg_pkg::draw_t                draw,
    output int                            err_count,
    output int                            pending_draws
);
    import erg_pkg::*;

    logic [CFG_BITS-1:0]  duration_us;
    logic [CFG_BITS-1:0]  snap_gap_us;
    logic [CTX_BITS-1:0]  prev_ctx;
    logic                 seen_frame;
    logic [TIME_BITS-1:0] prev_time;
    logic                 gliding;
    logic [TIME_BITS-1:0] glide_t0;
    longint               origin [NUM_COORDS];
    longint               goal [NUM_COORDS];
    longint               pos [NUM_COORDS];
    draw_t                queued_draws [$];

    function automatic longint ease_q16(input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] el;
        longint               r;
        longint               t;
        longint               t2;
        longint               t3;
        el = now - glide_t0;
        if (!gliding || el >= duration_us)
        begin
            return longint'(E_ONE);
        end
        r  = (longint'(el) << 16) / longint'(duration_us);
        t  = longint'(E_ONE) - r;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        return longint'(E_ONE) - t3;
    endfunction

    function automatic draw_t glide_draw(input frame_t f);
        longint                 tgt [NUM_COORDS];
        logic [TIME_BITS-1:0]   gap;
        logic                   jump;
        logic                   moved;
        longint                 e;
        longint                 diff;
        logic [COORD_BITS-1:0]  px [NUM_COORDS];
        tgt[0] = longint'($signed(f.target_x));
        tgt[1] = longint'($signed(f.target_y));
        tgt[2] = longint'($signed(f.target_w));
        tgt[3] = longint'($signed(f.target_h));
        gap    = f.time_us - prev_time;
        jump   = (f.context_id != prev_ctx) || !seen_frame ||
                 (gap > TIME_BITS'(snap_gap_us)) || f.tab_sliding;
        prev_ctx   = f.context_id;
        seen_frame = 1'b1;
        prev_time  = f.time_us;
        if (jump)
        begin
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                goal[i]   = tgt[i];
                origin[i] = tgt[i] <<< FRAC_BITS;
                pos[i]    = origin[i];
            end
            gliding = 1'b0;
        end
        else
        begin
            moved = 1'b0;
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                if (tgt[i] != goal[i])
                begin
                    moved = 1'b1;
                end
            end
            if (moved)
            begin
                for (int i = 0; i < NUM_COORDS; i++)
                begin
                    origin[i] = pos[i];
                    goal[i]   = tgt[i];
                end
                glide_t0 = f.time_us;
                gliding  = 1'b1;
            end
            e = ease_q16(f.time_us);
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                diff   = (goal[i] <<< FRAC_BITS) - origin[i];
                pos[i] = origin[i] + ((diff * e) >>> 16);
            end
        end
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            px[i] = COORD_BITS'((pos[i] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
        return {px[0], px[1], px[2], px[3]};
    endfunction

    task automatic check_coord(input string name, input logic signed [COORD_BITS-1:0] want,
                               input logic signed [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_t want;
        if (!rst_n)
        begin
            duration_us = GLIDE_DURATION_RESET;
            snap_gap_us = SNAP_GAP_RESET;
            prev_ctx    = '0;
            seen_frame  = 1'b0;
            prev_time   = '0;
            gliding     = 1'b0;
            glide_t0    = '0;
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                origin[i] = 0;
                goal[i]   = 0;
                pos[i]    = 0;
            end
            queued_draws.delete();
            err_count     = 0;
            pending_draws = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_GLIDE_DURATION, 2'b00})
                begin
                    duration_us = pwdata[CFG_BITS-1:0];
                end
                else if (paddr == {REG_SNAP_GAP, 2'b00})
                begin
                    snap_gap_us = pwdata[CFG_BITS-1:0];
                end
            end
            if (frame_valid && frame_ready)
            begin
                queued_draws.push_back(glide_draw(frame));
            end
            if (draw_valid && draw_ready)
            begin
                if (queued_draws.size() == 0)
                begin
                    err_count++;
                    $error("draw: result with no request waiting");
                end
                else
                begin
                    want = queued_draws.pop_front();
                    check_coord("draw_x", want.draw_x, draw.draw_x);
                    check_coord("draw_y", want.draw_y, draw.draw_y);
                    check_coord("draw_w", want.draw_w, draw.draw_w);
                    check_coord("draw_h", want.draw_h, draw.draw_h);
                end
            end
            pending_draws = queued_draws.size();
        end
    end

endmodule

// ===== bench/tb_eased_rect_glide_top.sv =====
// Testbench top for the eased rectangle glide block: drives frame requests and
// APB settings, stalls the draw side, and reports the verdict.
// Depends on erg_pkg, eased_rect_glide_top and erg_glide_checker.
`timescale 1ns / 1ps

module tb_eased_rect_glide_top;
    import erg_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 frame_valid = 1'b0;
    logic                 frame_ready;
    frame_t               frame       = '0;
    logic                 draw_valid;
    logic                 draw_ready  = 1'b0;
    draw_t                draw;
    int                   err_count;
    int                   pending_draws;

    bit                   no_idle     = 1'b0;
    bit                   hold_draws  = 1'b0;
    logic [CFG_BITS-1:0]  cur_duration = GLIDE_DURATION_RESET;
    logic [CFG_BITS-1:0]  cur_snap_gap = SNAP_GAP_RESET;
    logic [TIME_BITS-1:0] now_us       = '0;
    frame_t               last_sent    = '0;

    eased_rect_glide_top i_dut (.*);

    erg_glide_checker i_checker (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        if (r < 98)
        begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] v);
        return v + COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
    endfunction

    initial
    begin : draw_sink
        int hold_left;
        int idle_left;
        hold_left = 0;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                draw_ready <= 1'b0;
            end
            else if (hold_draws)
            begin
                hold_draws = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                draw_ready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                draw_ready <= 1'b0;
            end
            else
            begin
                draw_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                begin
                    idle_left = pick_gap();
                end
            end
        end
    end

    task automatic send_frame(input frame_t f);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame       <= f;
        frame_valid <= 1'b1;
        last_sent    = f;
        @(negedge clk);
        while (!frame_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_at(input logic [CTX_BITS-1:0] ctx,
                           input logic [4*COORD_BITS-1:0] rect,
                           input logic [TIME_BITS-1:0] step, input logic slide);
        frame_t f;
        now_us        = now_us + step;
        f.context_id  = ctx;
        {f.target_x, f.target_y, f.target_w, f.target_h} = rect;
        f.time_us     = now_us;
        f.tab_sliding = slide;
        send_frame(f);
    endtask

    task automatic send_random();
        frame_t               f;
        int                   r;
        logic [TIME_BITS-1:0] step_max;
        logic [TIME_BITS-1:0] step;
        f = last_sent;
        f.tab_sliding = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 29) == 0)
        begin
            f.context_id = CTX_BITS'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            f.target_x = nudge(f.target_x);
            f.target_y = nudge(f.target_y);
            f.target_w = nudge(f.target_w);
            f.target_h = nudge(f.target_h);
        end
        else if (r < 35)
        begin
            {f.target_x, f.target_y, f.target_w, f.target_h} = {$urandom, $urandom};
        end
        step_max = (cur_snap_gap < cur_duration / 6 + 1) ? cur_snap_gap : cur_duration / 6 + 1;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            step = $urandom_range(0, step_max);
        end
        else if (r < 86)
        begin
            step = cur_snap_gap;
        end
        else if (r < 95)
        begin
            step = cur_snap_gap + $urandom_range(1, 1000);
        end
        else
        begin
            step = $urandom;
        end
        now_us    = now_us + step;
        f.time_us = now_us;
        send_frame(f);
    endtask

    task automatic drain();
        frame_valid <= 1'b0;
        @(negedge clk);
        while (pending_draws != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_BITS-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GLIDE_DURATION)
        begin
            cur_duration = value;
        end
        else
        begin
            cur_snap_gap = value;
        end
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input logic [CFG_BITS-1:0] duration,
                             input logic [CFG_BITS-1:0] gap);
        drain();
        write_reg(REG_GLIDE_DURATION, duration);
        write_reg(REG_SNAP_GAP, gap);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 3)
            begin
                hold_draws = 1'b1;
            end
            if (n == count / 2)
            begin
                drain();
            end
            no_idle = (n >= 2 * count / 3) && (n < 5 * count / 6);
            send_random();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first draw, then a glide run to its exact end
        now_us = 32'd1000;
        send_at(8'h00, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, 32'd0, 1'b0);
        send_at(8'h00, {16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C}, 32'd10000, 1'b0);
        send_at(8'h00, {16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C}, 32'd40000, 1'b0);
        send_at(8'h00, {16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C}, 32'd60000, 1'b0);
        send_at(8'h00, {16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C}, 32'd70000, 1'b0);
        // gap at and just past the snap limit
        send_at(8'h00, {16'h0000, 16'h0000, 16'h0001, 16'h0001}, 32'd20000, 1'b0);
        send_at(8'h00, {16'h0000, 16'h0000, 16'h0001, 16'h0001}, 32'd120000, 1'b0);
        send_at(8'h00, {16'h0000, 16'h0000, 16'h0001, 16'h0001}, 32'd120001, 1'b0);
        // tab slide and context change
        send_at(8'h00, {16'h1234, 16'hEDCC, 16'h0200, 16'h0100}, 32'd1000, 1'b1);
        send_at(8'hFF, {16'h1234, 16'hEDCC, 16'h0200, 16'h0100}, 32'd1000, 1'b0);
        // timestamp wrap during a glide, then a restart mid-glide
        now_us = 32'hFFFF_FF00;
        send_at(8'hFF, {16'd10, 16'd20, 16'd30, 16'd40}, 32'd0, 1'b0);
        send_at(8'hFF, {-16'sd10, -16'sd20, -16'sd30, -16'sd40}, 32'h200, 1'b0);
        send_at(8'hFF, {-16'sd10, -16'sd20, -16'sd30, -16'sd40}, 32'd50000, 1'b0);
        send_at(8'hFF, {16'd500, 16'd600, -16'sd700, 16'd800}, 32'd50000, 1'b0);
        send_at(8'hFF, {16'd500, 16'd600, -16'sd700, 16'd800}, 32'd0, 1'b0);

        // zero duration jumps straight to the goal
        drain();
        write_reg(REG_GLIDE_DURATION, '0);
        send_at(8'hFF, {16'h4000, 16'hC000, 16'h0010, 16'h0020}, 32'd1000, 1'b0);
        send_at(8'hFF, {16'h3000, 16'hD000, 16'h0011, 16'h0021}, 32'd1000, 1'b0);

        // shortest duration with no tolerated gap
        drain();
        write_reg(REG_GLIDE_DURATION, 20'd1);
        write_reg(REG_SNAP_GAP, '0);
        send_at(8'hFF, {16'h0100, 16'h0200, 16'h0300, 16'h0400}, 32'd0, 1'b0);
        send_at(8'hFF, {16'h0100, 16'h0200, 16'h0300, 16'h0400}, 32'd0, 1'b0);
        send_at(8'hFF, {16'h0101, 16'h0200, 16'h0300, 16'h0400}, 32'd1, 1'b0);

        // widest settings, full-scale move
        drain();
        write_reg(REG_GLIDE_DURATION, 20'hFFFFF);
        write_reg(REG_SNAP_GAP, 20'hFFFFF);
        send_at(8'hFF, {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 32'd5000, 1'b0);
        send_at(8'hFF, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 32'd5000, 1'b0);
        send_at(8'hFF, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 32'd500000, 1'b0);
        send_at(8'hFF, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 32'hFFFFF, 1'b0);

        now_us = $urandom;
        run_phase(160, GLIDE_DURATION_RESET, SNAP_GAP_RESET);
        run_phase(60, 20'd1, 20'd0);
        run_phase(80, 20'hFFFFF, 20'hFFFFF);
        run_phase(60, 20'd0, 20'd1000);
        run_phase(160, 20'd5000, 20'd20000);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== eased_rect_glide_top.f =====
+incdir+src
src/erg_pkg.sv
src/erg_ctrl.sv
src/erg_dp.sv
src/eased_rect_glide_top.sv
src/erg_checker.sv
bench/erg_glide_checker.sv
bench/tb_eased_rect_glide_top.sv
